FILE: sv/stwg_pkg.sv
// Shared types, constants and the sine quarter-wave ROM for the stereo test waveform generator.
package stwg_pkg;

    // Sine table geometry: quarter wave with SINE_Q + 1 entries
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_Q          = 1 << SINE_TABLE_BITS;
    localparam int SINE_AW         = SINE_TABLE_BITS + 1;
    localparam logic [63:0] PI_HALF_Q31 = 64'd3373259426;

    // Command queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Full-scale levels
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        WAVE_SQUARE = 2'd0,
        WAVE_SINE   = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_TRI    = 2'd3
    } wave_t;

    typedef enum logic [2:0] {
        CFG_WAVE_MODE   = 3'd0,
        CFG_SQUARE_HALF = 3'd1,
        CFG_SINE_STEP   = 3'd2,
        CFG_SAW_STEP    = 3'd3,
        CFG_TRI_STEP    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        wave_t        mode;
        logic [15:0]  square_half_period;
        logic [31:0]  sine_phase_step;
        logic [30:0]  saw_step;
        logic [30:0]  tri_step;
    } cfg_t;

    // Queue occupancy flags seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef logic [31:0] sine_rom_t [SINE_Q + 1];

    // Taylor series for sin(pi/2 * k / SINE_Q), unsigned Q31, clamped
    function automatic logic [31:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        x    = (PI_HALF_Q31 * 64'(k)) >> SINE_TABLE_BITS;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x) >> 31) / 64'(2 * n);
            term = ((term * x) >> 31) / 64'(2 * n + 1);
            if ((n % 2) == 1) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        if (sum < 0)           sum = 0;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        return sum[31:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k <= SINE_Q; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: sv/stwg_front.sv
// Front end: takes tick words, drops empty ones, queues a command per tick.
module stwg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [0] tick, [7:1] zero
    input  stwg_pkg::wave_t    mode,
    input  stwg_pkg::q_status_t q_status,
    output logic               push,
    output stwg_pkg::wave_t    push_cmd
);

    // Accept while the queue has room
    assign s_axis_tready = !q_status.full;

    // A word with tick clear causes no sample
    assign push     = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];
    assign push_cmd = mode;

    property p_no_push_when_full;
        @(posedge aclk) disable iff (!aresetn) q_status.full |-> !push;
    endproperty
    a_no_push_when_full: assert property (p_no_push_when_full)
        else $error("push into full queue");

    property p_push_needs_tick;
        @(posedge aclk) disable iff (!aresetn) push |-> s_axis_tdata[0] && s_axis_tvalid;
    endproperty
    a_push_needs_tick: assert property (p_push_needs_tick)
        else $error("push without tick");

    property p_stall_on_full;
        @(posedge aclk) disable iff (!aresetn)
            (s_axis_tvalid && q_status.full) |-> !s_axis_tready;
    endproperty
    a_stall_on_full: assert property (p_stall_on_full)
        else $error("ready while queue full");

endmodule

FILE: sv/stwg_queue.sv
// Short command queue that decouples the front end from the sample engine.
module stwg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  stwg_pkg::wave_t     push_cmd,
    input  logic                pop,
    output stwg_pkg::wave_t     pop_cmd,
    output stwg_pkg::q_status_t q_status
);

    stwg_pkg::wave_t                 entry_reg [stwg_pkg::QUEUE_DEPTH];
    logic [stwg_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [stwg_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [stwg_pkg::QUEUE_AW:0]     count_reg, count_next;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_cmd;
    end

    assign pop_cmd        = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == (stwg_pkg::QUEUE_AW+1)'(stwg_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn)
            count_reg <= (stwg_pkg::QUEUE_AW+1)'(stwg_pkg::QUEUE_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("queue count over depth");

    property p_no_pop_empty;
        @(posedge aclk) disable iff (!aresetn) pop |-> !q_status.empty;
    endproperty
    a_no_pop_empty: assert property (p_no_pop_empty)
        else $error("pop from empty queue");

    property p_count_tracks;
        @(posedge aclk) disable iff (!aresetn)
            (push && !pop) |=> count_reg == $past(count_reg) + 1'b1;
    endproperty
    a_count_tracks: assert property (p_count_tracks)
        else $error("queue count lost a push");

endmodule

FILE: sv/stwg_back.sv
// Sample engine: waveform state, sine ROM read and the output register.
module stwg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  stwg_pkg::cfg_t      cfg,
    input  stwg_pkg::q_status_t q_status,
    input  stwg_pkg::wave_t     pop_cmd,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata    // [31:0] left_sample, [63:32] right_sample
);

    typedef struct packed {
        logic signed [31:0] v;
        logic               rising;
    } tri_state_t;

    // One triangle channel: bounce between the limits
    function automatic tri_state_t tri_move(input logic signed [31:0] v,
                                            input logic rising,
                                            input logic [30:0] step);
        tri_state_t         res;
        logic signed [33:0] vs;
        logic signed [33:0] st;
        logic signed [33:0] sum;
        vs  = $signed({{2{v[31]}}, v});
        st  = $signed({3'b000, step});
        res.v      = v;
        res.rising = rising;
        if (rising) begin
            sum = vs + st;
            if (vs >= ($signed({{2{stwg_pkg::S32_MAX[31]}}, stwg_pkg::S32_MAX}) - st))
                res.rising = 1'b0;
            else
                res.v = sum[31:0];
        end else begin
            sum = vs - st;
            if (vs <= ($signed({{2{stwg_pkg::S32_MIN[31]}}, stwg_pkg::S32_MIN}) + st))
                res.rising = 1'b1;
            else
                res.v = sum[31:0];
        end
        return res;
    endfunction

    // Waveform state
    logic [15:0]         sq_count_reg, sq_count_next;
    logic                sq_left_high_reg, sq_left_high_next;
    logic                sq_right_high_reg, sq_right_high_next;
    logic [31:0]         sine_phase_reg, sine_phase_next;
    logic signed [31:0]  saw_left_reg, saw_left_next;
    logic signed [31:0]  saw_right_reg, saw_right_next;
    tri_state_t          tri_left_reg, tri_left_next;
    tri_state_t          tri_right_reg, tri_right_next;

    // Compute stage
    logic                a_valid_reg;
    logic                a_sine_reg;
    logic                a_neg_reg;
    logic signed [31:0]  a_left_reg, a_left_next;
    logic signed [31:0]  a_right_reg, a_right_next;
    logic [31:0]         rom_data_reg;

    // Output stage
    logic                m_valid_reg;
    logic signed [31:0]  m_left_reg, m_left_next;
    logic signed [31:0]  m_right_reg, m_right_next;

    logic                b_en;
    logic                a_en;
    logic [16:0]         sq_count_inc;
    logic signed [33:0]  saw_l_sum;
    logic signed [33:0]  saw_r_sum;
    logic [stwg_pkg::SINE_TABLE_BITS-1:0] sine_idx;
    logic [stwg_pkg::SINE_AW-1:0]         rom_addr;
    logic signed [31:0]  sine_right;

    // Stall chain
    assign b_en = !m_valid_reg || m_axis_tready;
    assign a_en = !a_valid_reg || b_en;
    assign pop  = a_en && !q_status.empty;

    // Per-waveform update for the popped command
    always_comb begin
        sq_count_next      = sq_count_reg;
        sq_left_high_next  = sq_left_high_reg;
        sq_right_high_next = sq_right_high_reg;
        sine_phase_next    = sine_phase_reg;
        saw_left_next      = saw_left_reg;
        saw_right_next     = saw_right_reg;
        tri_left_next      = tri_left_reg;
        tri_right_next     = tri_right_reg;
        a_left_next        = '0;
        a_right_next       = '0;
        sq_count_inc = {1'b0, sq_count_reg} + 17'd1;
        saw_l_sum    = $signed({{2{saw_left_reg[31]}}, saw_left_reg})
                     + $signed({3'b000, cfg.saw_step});
        saw_r_sum    = $signed({{2{saw_right_reg[31]}}, saw_right_reg})
                     - $signed({3'b000, cfg.saw_step});
        unique case (pop_cmd)
            stwg_pkg::WAVE_SQUARE: begin
                a_left_next  = sq_left_high_reg  ? stwg_pkg::S32_MAX : stwg_pkg::S32_MIN;
                a_right_next = sq_right_high_reg ? stwg_pkg::S32_MAX : stwg_pkg::S32_MIN;
                if (sq_count_inc >= {1'b0, cfg.square_half_period}) begin
                    sq_left_high_next  = !sq_left_high_reg;
                    sq_right_high_next = !sq_right_high_reg;
                    sq_count_next      = '0;
                end else begin
                    sq_count_next = sq_count_inc[15:0];
                end
            end
            stwg_pkg::WAVE_SINE: begin
                sine_phase_next = sine_phase_reg + cfg.sine_phase_step;
            end
            stwg_pkg::WAVE_SAW: begin
                a_left_next  = saw_left_reg;
                a_right_next = saw_right_reg;
                saw_left_next  = (saw_l_sum >= 34'sd2147483647) ? stwg_pkg::S32_MIN
                                                                 : saw_l_sum[31:0];
                saw_right_next = (saw_r_sum <= -34'sd2147483647) ? stwg_pkg::S32_MAX
                                                                  : saw_r_sum[31:0];
            end
            stwg_pkg::WAVE_TRI: begin
                tri_left_next  = tri_move(tri_left_reg.v, tri_left_reg.rising, cfg.tri_step);
                tri_right_next = tri_move(tri_right_reg.v, tri_right_reg.rising, cfg.tri_step);
                a_left_next    = tri_left_next.v;
                a_right_next   = tri_right_next.v;
            end
            default: ;
        endcase
    end

    // Quarter-wave address from the advanced phase
    assign sine_idx = sine_phase_next[29 -: stwg_pkg::SINE_TABLE_BITS];
    assign rom_addr = sine_phase_next[30]
                    ? (stwg_pkg::SINE_AW'(stwg_pkg::SINE_Q) - {1'b0, sine_idx})
                    : {1'b0, sine_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_count_reg      <= '0;
            sq_left_high_reg  <= 1'b1;
            sq_right_high_reg <= 1'b0;
            sine_phase_reg    <= '0;
            saw_left_reg      <= '0;
            saw_right_reg     <= '0;
            tri_left_reg      <= '{v: '0, rising: 1'b1};
            tri_right_reg     <= '{v: '0, rising: 1'b0};
        end else if (pop) begin
            sq_count_reg      <= sq_count_next;
            sq_left_high_reg  <= sq_left_high_next;
            sq_right_high_reg <= sq_right_high_next;
            sine_phase_reg    <= sine_phase_next;
            saw_left_reg      <= saw_left_next;
            saw_right_reg     <= saw_right_next;
            tri_left_reg      <= tri_left_next;
            tri_right_reg     <= tri_right_next;
        end
    end

    // Compute stage register and ROM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_en) begin
            a_valid_reg <= pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_sine_reg   <= (pop_cmd == stwg_pkg::WAVE_SINE);
            a_neg_reg    <= sine_phase_next[31];
            a_left_reg   <= a_left_next;
            a_right_reg  <= a_right_next;
            rom_data_reg <= stwg_pkg::SINE_ROM[rom_addr];
        end
    end

    // Sine sign resolve: right is the sine, left its negation
    assign sine_right   = a_neg_reg ? -$signed(rom_data_reg) : $signed(rom_data_reg);
    assign m_left_next  = a_sine_reg ? -sine_right : a_left_reg;
    assign m_right_next = a_sine_reg ? sine_right  : a_right_reg;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_en) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            m_left_reg  <= m_left_next;
            m_right_reg <= m_right_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_right_reg, m_left_reg};

    property p_square_antiphase;
        @(posedge aclk) disable iff (!aresetn) sq_left_high_reg != sq_right_high_reg;
    endproperty
    a_square_antiphase: assert property (p_square_antiphase)
        else $error("square channels lost antiphase");

    property p_stage_held;
        @(posedge aclk) disable iff (!aresetn)
            (a_valid_reg && m_valid_reg && !m_axis_tready) |=> a_valid_reg;
    endproperty
    a_stage_held: assert property (p_stage_held)
        else $error("compute stage dropped a word under stall");

    property p_pop_only_with_room;
        @(posedge aclk) disable iff (!aresetn)
            (a_valid_reg && m_valid_reg && !m_axis_tready) |-> !pop;
    endproperty
    a_pop_only_with_room: assert property (p_pop_only_with_room)
        else $error("pop while pipeline stalled");

    property p_reset_empty;
        @(posedge aclk) !aresetn |=> !a_valid_reg && !m_valid_reg;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("pipeline not empty after reset");

endmodule

FILE: sv/stereo_test_waveform_generator_top.sv
// Top level of the stereo test waveform generator: configuration registers and block wiring.
//
// Every input word with tick set yields one stereo word, left sample in the low half and
// right sample in the high half of m_axis_tdata; words with tick clear are consumed and
// give nothing. The block takes one word per cycle while the queue has room and delivers
// one per cycle while the output is taken; the state of the selected waveform advances
// once per word. An accepted word passes through the four-entry command queue and the
// compute stage, where the sine quarter-wave ROM is read through a registered port, and is
// then held in the output register. The queue keeps accepting while a finished sample
// waits, as long as it has room. Registers written on cfg_we take effect for ticks that
// leave the queue afterwards (mode: for ticks accepted afterwards) and are meant to be
// changed only with the block idle. Each waveform keeps its own state and advances only
// while selected.
module stereo_test_waveform_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [0] tick, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,    // [31:0] left_sample, [63:32] right_sample
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    stwg_pkg::cfg_t      cfg_reg;
    stwg_pkg::q_status_t q_status;
    stwg_pkg::wave_t     push_cmd;
    stwg_pkg::wave_t     pop_cmd;
    logic                push;
    logic                pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode               <= stwg_pkg::WAVE_SQUARE;
            cfg_reg.square_half_period <= 16'd192;
            cfg_reg.sine_phase_step    <= 32'd11184811;
            cfg_reg.saw_step           <= 31'd11184810;
            cfg_reg.tri_step           <= 31'd22369621;
        end else if (cfg_we) begin
            unique case (stwg_pkg::cfg_idx_t'(cfg_addr))
                stwg_pkg::CFG_WAVE_MODE:   cfg_reg.mode <= stwg_pkg::wave_t'(cfg_wdata[1:0]);
                stwg_pkg::CFG_SQUARE_HALF: cfg_reg.square_half_period <= cfg_wdata[15:0];
                stwg_pkg::CFG_SINE_STEP:   cfg_reg.sine_phase_step <= cfg_wdata;
                stwg_pkg::CFG_SAW_STEP:    cfg_reg.saw_step <= cfg_wdata[30:0];
                stwg_pkg::CFG_TRI_STEP:    cfg_reg.tri_step <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    stwg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .mode          (cfg_reg.mode),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    stwg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    stwg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_status      (q_status),
        .pop_cmd       (pop_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
